/* rtl/u8n1_pkg.sv */
// Package for the 8N1 UART transceiver: item types, configuration register
// indexes and counter widths shared by the receiver, transmitter and top level.
// Depends on nothing.
package u8n1_pkg;

    // Width of the bit-timing countdowns.
    localparam int CNT_W = 16;
    // Width of the configuration write data, the widest register.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int DATA_BITS = 8;
    localparam int BIT_IDX_W = 3;

    typedef logic [CNT_W-1:0] t_cnt;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SAMPLE_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] BIT_PERIOD_RST = 16'd104;
    localparam logic [15:0] FIRST_SAMPLE_DELAY_RST = 16'd156;

    typedef struct packed {
        logic [15:0] bit_period;
        logic [15:0] first_sample_delay;
        logic        rx_enable;
    } t_cfg;

    typedef struct packed {
        logic       rx_line;
        logic       send_request;
        logic [7:0] send_byte;
    } t_in_item;

    typedef struct packed {
        logic       tx_line;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_done;
        logic       tx_busy;
    } t_out_item;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_rx_res;

    typedef struct packed {
        logic tx_line;
        logic tx_done;
        logic tx_busy;
    } t_tx_res;

    // Converts a 16-bit register value into a countdown load value.
    function automatic t_cnt cnt_load(logic [15:0] v);
        return CNT_W'(v);
    endfunction

endpackage

/* rtl/uart_8n1_transceiver.sv */
// Top level of the 8N1 UART transceiver: configuration registers, receiver and
// transmitter instances, and the two-entry result buffer. Depends on u8n1_pkg.
//
// Usage: every input item is one timebase tick. It carries the receive pin
// level, a send request and the byte to send. Every accepted item produces
// exactly one result item with the transmit pin level, a one-tick receive
// strobe with the last received byte, a one-tick transmit done strobe and the
// transmitter busy flag, all as they stand after that tick.
// Results are registered; a result goes to the skid register while the result
// register is stalled. Throughput is one item per cycle while o_in_ready is high;
// the bit timing counters in the receiver and transmitter advance once per
// accepted item, so the serial rate is set by bit_period in items, not cycles.
// The result register is backed by a skid register. When the result consumer
// stalls, one more item is still accepted into the skid register, and then
// o_in_ready drops until the consumer takes a result. Stalls on either side
// only pause the tick stream; they never change the serial timing.
// Configuration is a plain write port: i_cfg_we with i_cfg_index selects the
// register (0 bit_period, 1 first_sample_delay, 2 rx_enable); index 3 is
// ignored. Writes are meant for idle periods only.
// Synchronous reset returns both state machines to idle, the transmit line to
// high, the configuration to 104 / 156 / disabled, and empties the buffer.
module uart_8n1_transceiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  u8n1_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output u8n1_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [u8n1_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [u8n1_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import u8n1_pkg::*;

    t_cfg      r_cfg;
    t_rx_res   rx_res;
    t_tx_res   tx_res;
    t_out_item new_item;
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_fire;
    logic      out_fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period         <= BIT_PERIOD_RST;
            r_cfg.first_sample_delay <= FIRST_SAMPLE_DELAY_RST;
            r_cfg.rx_enable          <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIT_PERIOD:         r_cfg.bit_period <= i_cfg_data;
                CFG_FIRST_SAMPLE_DELAY: r_cfg.first_sample_delay <= i_cfg_data;
                CFG_RX_ENABLE:          r_cfg.rx_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The skid register is the only thing that can hold off new items.
    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    u8n1_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_fire),
        .i_rx_line (i_in_item.rx_line),
        .i_cfg     (r_cfg),
        .o_res     (rx_res)
    );

    u8n1_tx u_tx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (in_fire),
        .i_send_request (i_in_item.send_request),
        .i_send_byte    (i_in_item.send_byte),
        .i_bit_period   (r_cfg.bit_period),
        .o_res          (tx_res)
    );

    always_comb begin
        new_item.tx_line  = tx_res.tx_line;
        new_item.rx_valid = rx_res.rx_valid;
        new_item.rx_byte  = rx_res.rx_byte;
        new_item.tx_done  = tx_res.tx_done;
        new_item.tx_busy  = tx_res.tx_busy;
    end

    // Result register with skid register behind it. A new item can only
    // arrive while the skid register is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= new_item;
            end
        end else if (in_fire) begin
            r_skid <= new_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The skid register is only ever filled behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the result register is empty");

    // An accepted item always leaves a result waiting after the edge.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted item produced no result");

    // A stalled result and another accepted item must block input on the next cycle.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && in_fire) |=> !o_in_ready)
        else $error("input not blocked with both result registers full");

    // The transmitter drops busy on the tick it reports done.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.tx_done && r_out.tx_busy))
        else $error("tx_done and tx_busy set in the same result");

endmodule

/* rtl/u8n1_rx.sv */
// Receiver of the 8N1 UART transceiver: start-edge detection, bit timing and
// the receive shift register. Depends on u8n1_pkg.
module u8n1_rx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_rx_line,
    input  u8n1_pkg::t_cfg    i_cfg,
    output u8n1_pkg::t_rx_res o_res
);
    import u8n1_pkg::*;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_DATA,
        RX_STOP
    } t_rx_state;

    t_rx_state            r_state, n_state;
    t_cnt                 r_cnt, n_cnt;
    logic [BIT_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]           r_shift, n_shift;
    logic                 r_prev;
    logic [7:0]           r_hold, n_hold;
    logic                 n_valid;
    logic                 expired;

    assign expired = (r_cnt <= CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_hold  = r_hold;
        n_valid = 1'b0;
        case (r_state)
            RX_IDLE: begin
                if (i_cfg.rx_enable && r_prev && !i_rx_line) begin
                    n_cnt   = cnt_load(i_cfg.first_sample_delay);
                    n_idx   = '0;
                    n_state = RX_DATA;
                end
            end
            RX_DATA: begin
                if (expired) begin
                    n_shift = {i_rx_line, r_shift[7:1]};
                    n_cnt   = cnt_load(i_cfg.bit_period);
                    if (r_idx == BIT_IDX_W'(DATA_BITS - 1)) begin
                        n_state = RX_STOP;
                    end else begin
                        n_idx = r_idx + BIT_IDX_W'(1);
                    end
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            RX_STOP: begin
                if (expired) begin
                    // The stop bit is not checked; the byte is delivered as is.
                    n_hold  = r_shift;
                    n_valid = 1'b1;
                    n_state = RX_IDLE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_state = RX_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_shift <= '0;
            r_prev  <= 1'b1;
            r_hold  <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_prev  <= i_rx_line;
            r_hold  <= n_hold;
        end
    end

    assign o_res.rx_valid = n_valid;
    assign o_res.rx_byte  = n_hold;

endmodule

/* rtl/u8n1_tx.sv */
// Transmitter of the 8N1 UART transceiver: frame sequencing, bit timing and
// the transmit shift register. Depends on u8n1_pkg.
module u8n1_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_send_request,
    input  logic [7:0]        i_send_byte,
    input  logic [15:0]       i_bit_period,
    output u8n1_pkg::t_tx_res o_res
);
    import u8n1_pkg::*;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP
    } t_tx_state;

    t_tx_state            r_state, n_state;
    t_cnt                 r_cnt, n_cnt;
    logic [BIT_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]           r_shift, n_shift;
    logic                 r_level, n_level;
    logic                 n_done;
    logic                 expired;

    assign expired = (r_cnt <= CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_level = r_level;
        n_done  = 1'b0;
        case (r_state)
            TX_IDLE: begin
                if (i_send_request) begin
                    n_shift = i_send_byte;
                    n_level = 1'b0;
                    n_cnt   = cnt_load(i_bit_period);
                    n_state = TX_START;
                end
            end
            TX_START: begin
                if (expired) begin
                    n_level = r_shift[0];
                    n_shift = {1'b1, r_shift[7:1]};
                    n_cnt   = cnt_load(i_bit_period);
                    n_idx   = '0;
                    n_state = TX_DATA;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            TX_DATA: begin
                if (expired) begin
                    n_cnt = cnt_load(i_bit_period);
                    if (r_idx == BIT_IDX_W'(DATA_BITS - 1)) begin
                        n_level = 1'b1;
                        n_state = TX_STOP;
                    end else begin
                        n_level = r_shift[0];
                        n_shift = {1'b1, r_shift[7:1]};
                        n_idx   = r_idx + BIT_IDX_W'(1);
                    end
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            TX_STOP: begin
                if (expired) begin
                    n_level = 1'b1;
                    n_done  = 1'b1;
                    n_state = TX_IDLE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_level = 1'b1;
                n_state = TX_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TX_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_shift <= '0;
            r_level <= 1'b1;
        end else if (i_fire) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_level <= n_level;
        end
    end

    assign o_res.tx_line = n_level;
    assign o_res.tx_done = n_done;
    assign o_res.tx_busy = (n_state != TX_IDLE);

endmodule

/* tb/uart_8n1_transceiver_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 8N1 UART transceiver: drives tick items, predicts
// every result item with an in-bench cycle model and compares them field by field.
// Depends on u8n1_pkg and the uart_8n1_transceiver RTL.
module uart_8n1_transceiver_tb;
    import u8n1_pkg::*;

    // The limit leaves a wide margin over a normal run, even with every stall the
    // bench can produce.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int IDLE_PCT = 36;
    localparam int RX_HOLD_CYCLES = 250;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 175;
    localparam logic [15:0] WIDEST = 16'hFFFF;
    // A short stretch of ticks at the widest period: enough to start a frame
    // in each direction and watch both sides hold their first bit.
    localparam int LONG_TICKS = 48;

    // Receiver stages: idle, data bits one to eight, stop-bit time.
    localparam logic [3:0] RX_IDLE = 4'd0;
    localparam logic [3:0] RX_FIRST_BIT = 4'd1;
    localparam logic [3:0] RX_LAST_BIT = 4'd8;
    localparam logic [3:0] RX_STOP_TIME = 4'd9;
    // Transmitter stages: idle, start bit, data bits, stop bit.
    localparam logic [3:0] TX_IDLE = 4'd0;
    localparam logic [3:0] TX_START_BIT = 4'd1;
    localparam logic [3:0] TX_STOP_BIT = 4'd10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_item;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    uart_8n1_transceiver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Ticks waiting to be offered, and the pin states predicted for accepted ticks.
    t_in_item ticks_to_send[$];
    t_out_item expected_pins[$];

    // Testbench copy of the configuration registers, at their reset values.
    logic [15:0] cfg_bit_period = 16'd104;
    logic [15:0] cfg_sample_delay = 16'd156;
    logic cfg_rx_on = 1'b0;

    // Testbench copy of the receiver and transmitter state, at reset values.
    logic [3:0] rx_stage = RX_IDLE;
    t_cnt rx_count = '0;
    logic [7:0] rx_shift = '0;
    logic rx_prev_line = 1'b1;
    logic [7:0] rx_last_byte = '0;
    logic [3:0] tx_stage = TX_IDLE;
    t_cnt tx_count = '0;
    logic [7:0] tx_shift = '0;
    logic tx_pin = 1'b1;

    bit in_took = 1'b0;
    bit idle_on = 1'b1;
    bit rx_stall_ask = 1'b0;
    bit rx_stall_used = 1'b0;
    int stall_left = 0;
    int errors = 0;
    int cycle_count = 0;

    // Bit period and first-sample delay per random phase, with the receive
    // enable and the chance of a send request on a tick (per thousand).
    int phase_period [PHASE_COUNT] = '{3, 1, 2, 0, 4, 5, 1, 6, 2, 3};
    int phase_delay [PHASE_COUNT] = '{4, 1, 3, 0, 6, 7, 2, 9, 12, 20};
    int phase_enable [PHASE_COUNT] = '{0, 1, 1, 1, 1, 1, 1, 1, 0, 1};
    int phase_req_pm [PHASE_COUNT] = '{150, 100, 400, 80, 1000, 200, 120, 60, 300, 150};

    // Advances the transceiver by one tick and returns the pin states after it.
    // A countdown that holds 0 or 1 expires on this tick, so a load of zero
    // behaves like a one-tick bit.
    function automatic t_out_item uart_tick(input t_in_item it);
        t_out_item res;
        logic byte_strobe;
        logic frame_end;
        byte_strobe = 1'b0;
        frame_end = 1'b0;

        // Receiver. Only the start-bit search looks at the enable, so a frame
        // already under way always runs to its stop-bit time.
        if (rx_stage == RX_IDLE) begin
            if (cfg_rx_on && rx_prev_line && !it.rx_line) begin
                rx_count = cfg_sample_delay;
                rx_stage = RX_FIRST_BIT;
            end
        end else if (rx_stage <= RX_STOP_TIME) begin
            if (rx_count > 1) begin
                rx_count = rx_count - 1'b1;
            end else if (rx_stage <= RX_LAST_BIT) begin
                rx_shift = {it.rx_line, rx_shift[7:1]};
                rx_count = cfg_bit_period;
                rx_stage = rx_stage + 1'b1;
            end else begin
                // The stop bit is not looked at: the byte is handed over anyway.
                rx_last_byte = rx_shift;
                byte_strobe = 1'b1;
                rx_stage = RX_IDLE;
            end
        end else begin
            rx_stage = RX_IDLE;
        end
        rx_prev_line = it.rx_line;

        // Transmitter. A request only counts while idle at the start of the
        // tick, so one on the done tick is dropped.
        if (tx_stage == TX_IDLE) begin
            if (it.send_request) begin
                tx_shift = it.send_byte;
                tx_pin = 1'b0;
                tx_count = cfg_bit_period;
                tx_stage = TX_START_BIT;
            end
        end else if (tx_stage <= TX_STOP_BIT) begin
            if (tx_count > 1) begin
                tx_count = tx_count - 1'b1;
            end else if (tx_stage < TX_STOP_BIT) begin
                // Ones shift in from the top, so the ninth bit out is the stop bit.
                tx_pin = tx_shift[0];
                tx_shift = {1'b1, tx_shift[7:1]};
                tx_count = cfg_bit_period;
                tx_stage = tx_stage + 1'b1;
            end else begin
                tx_pin = 1'b1;
                frame_end = 1'b1;
                tx_stage = TX_IDLE;
            end
        end else begin
            tx_stage = TX_IDLE;
            tx_pin = 1'b1;
        end

        res.tx_line = tx_pin;
        res.rx_valid = byte_strobe;
        res.rx_byte = rx_last_byte;
        res.tx_done = frame_end;
        res.tx_busy = (tx_stage != TX_IDLE);
        return res;
    endfunction

    task automatic push_tick(input logic line, input logic req, input logic [7:0] data);
        t_in_item it;
        it.rx_line = line;
        it.send_request = req;
        it.send_byte = data;
        ticks_to_send.push_back(it);
    endtask

    // Writes one register at a falling edge. No tick is in flight when this is
    // called, so the testbench copy can take the new value at once.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BIT_PERIOD: begin
                cfg_bit_period = data;
            end
            CFG_FIRST_SAMPLE_DELAY: begin
                cfg_sample_delay = data;
            end
            CFG_RX_ENABLE: begin
                cfg_rx_on = data[0];
            end
            default: begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_uart(input int period, input int delay, input int enable);
        write_reg(CFG_BIT_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_FIRST_SAMPLE_DELAY, CFG_DATA_W'(delay));
        write_reg(CFG_RX_ENABLE, CFG_DATA_W'(enable));
    endtask

    // Waits until every queued tick has been taken and every predicted result
    // has come back.
    task automatic wait_idle();
        while (ticks_to_send.size() != 0 || in_valid || expected_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Random ticks for one phase. The receive line is mostly well-formed frames
    // at the configured bit length, some with a low stop bit, mixed with short
    // bursts of noise. Send requests are independent of the line.
    task automatic run_phase(input int n, input int req_pm);
        bit line_q[$];
        int blen;
        int k;
        int b;
        bit stop_level;
        logic [7:0] data;
        blen = (cfg_bit_period == 0) ? 1 : int'(cfg_bit_period);
        while (line_q.size() < n) begin
            if ($urandom_range(0, 99) < 78) begin
                data = 8'($urandom);
                stop_level = ($urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, 4)) line_q.push_back(1'b1);
                repeat (blen) line_q.push_back(1'b0);
                for (b = 0; b < 8; b++)
                    repeat (blen) line_q.push_back(data[b]);
                repeat (blen) line_q.push_back(stop_level);
            end else begin
                repeat ($urandom_range(1, 8)) line_q.push_back(1'($urandom_range(0, 1)));
            end
        end
        for (k = 0; k < n; k++)
            push_tick(line_q[k], $urandom_range(0, 999) < req_pm, 8'($urandom));
    endtask

    // Input side: predict the result of each tick as it is accepted.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            expected_pins.push_back(uart_tick(in_item));
            in_took = 1'b1;
        end
    end

    // Driver: offers the next queued tick, with random gaps while idling is on.
    // The payload only changes when nothing is offered or the last item went in.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_took)) begin
            in_took = 1'b0;
            if (ticks_to_send.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_item <= ticks_to_send.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result-side ready. Once asked, it holds off for a long stretch while the
    // sender keeps offering, so the skid buffer fills and input ready drops.
    always @(negedge clk) begin
        if (rst_n) begin
            if (rx_stall_ask && !rx_stall_used && in_valid) begin
                rx_stall_used = 1'b1;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Monitor: every accepted result must match the oldest prediction.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_pins.size() == 0) begin
                $error("result item with no prediction pending: %h", out_item);
                errors++;
            end else begin
                want = expected_pins.pop_front();
                if (out_item.tx_line !== want.tx_line) begin
                    $error("tx_line: expected %0d, actual %0d", want.tx_line, out_item.tx_line);
                    errors++;
                end
                if (out_item.rx_valid !== want.rx_valid) begin
                    $error("rx_valid: expected %0d, actual %0d",
                           want.rx_valid, out_item.rx_valid);
                    errors++;
                end
                if (out_item.rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected %0h, actual %0h", want.rx_byte, out_item.rx_byte);
                    errors++;
                end
                if (out_item.tx_done !== want.tx_done) begin
                    $error("tx_done: expected %0d, actual %0d", want.tx_done, out_item.tx_done);
                    errors++;
                end
                if (out_item.tx_busy !== want.tx_busy) begin
                    $error("tx_busy: expected %0d, actual %0d", want.tx_busy, out_item.tx_busy);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int k;
        int p;
        logic line;
        logic [7:0] tx_data;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Zero period and delay act as one tick per bit, so a
        // whole frame fits in a few ticks. The line carries 0xFF with a low
        // stop bit (the byte still comes out, and a new start needs the line
        // to rise first), then 0x00. The send request stays high throughout:
        // requests while busy and on the done tick are dropped, and the next
        // frame starts on the tick after done.
        set_uart(0, 0, 1);
        for (k = 0; k < 22; k++) begin
            if (k == 1 || k == 10 || (k >= 12 && k <= 20))
                line = 1'b0;
            else
                line = 1'b1;
            push_tick(line, 1'b1, (k < 11) ? 8'hFF : 8'h00);
        end
        wait_idle();

        // Start a reception, then drop the enable in the middle of it. The
        // first random phase runs with reception disabled, and the frame
        // under way still has to finish.
        set_uart(3, 4, 1);
        push_tick(1'b1, 1'b0, 8'h00);
        push_tick(1'b1, 1'b0, 8'h00);
        push_tick(1'b0, 1'b0, 8'h00);
        push_tick(1'b0, 1'b0, 8'h00);
        push_tick(1'b0, 1'b0, 8'h00);
        wait_idle();

        // Random phases over a spread of small periods and delays. Phase 2
        // holds the result side off for a long stretch; phase 6 runs without
        // any idling. The wait between phases is also a full sender pause.
        for (p = 0; p < PHASE_COUNT; p++) begin
            set_uart(phase_period[p], phase_delay[p], phase_enable[p]);
            idle_on = (p != 6);
            rx_stall_ask = (p == 2);
            run_phase(PHASE_ITEMS, phase_req_pm[p]);
            wait_idle();
        end
        rx_stall_ask = 1'b0;

        // Widest period and delay: a send request and a start edge load both
        // countdowns from the full 16-bit values, and the following ticks check
        // that the start bit and the first-sample wait hold.
        set_uart(WIDEST, WIDEST, 1);
        idle_on = 1'b0;
        tx_data = 8'($urandom);
        for (k = 0; k < LONG_TICKS; k++)
            push_tick(k == 0, k == 0, tx_data);
        wait_idle();
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/u8n1_pkg.sv
rtl/u8n1_rx.sv
rtl/u8n1_tx.sv
rtl/uart_8n1_transceiver.sv
tb/uart_8n1_transceiver_tb.sv
